[hdl/mcoa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcoa_pkg
// Shared types and codes for the motion command owner arbiter: action codes,
// status codes, source codes, the register map and the register reset values.
// ----------------------------------------------------------------------------
package mcoa_pkg;

    // Requested action of one command transaction.
    typedef enum logic [2:0] {
        ACT_ACQUIRE = 3'd0,
        ACT_RELEASE = 3'd1,
        ACT_SUBMIT  = 3'd2,
        ACT_REFRESH = 3'd3,
        ACT_CLEAR   = 3'd4,
        ACT_QUERY   = 3'd5
    } t_action;

    // Result status of one transaction.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_REFUSED   = 2'd1,
        ST_INVALID   = 2'd2,
        ST_NOT_OWNER = 2'd3
    } t_status;

    // Source codes; codes above SRC_UPDATE are invalid.
    localparam logic [2:0] SRC_NONE     = 3'd0;
    localparam logic [2:0] SRC_REMOTE   = 3'd1;
    localparam logic [2:0] SRC_CONSOLE  = 3'd2;
    localparam logic [2:0] SRC_SELFTEST = 3'd3;
    localparam logic [2:0] SRC_UPDATE   = 3'd4;

    // Register map, indexed by byte address bit 2.
    localparam logic REG_TARGET_LIMIT = 1'b0;
    localparam logic REG_TIMEOUT_MS   = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [14:0] TARGET_LIMIT_RESET = 15'd10000;
    localparam logic [15:0] TIMEOUT_MS_RESET   = 16'd100;

endpackage : mcoa_pkg
`default_nettype wire

[hdl/mcoa_channels.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcoa_cmd_if / mcoa_rsp_if
// Valid/ready channels that carry command transactions into the arbiter and
// result transactions out of it.
// ----------------------------------------------------------------------------

// Command channel: one action request per transaction.
interface mcoa_cmd_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  action;
    logic        [2:0]  req_source;
    logic               seq_flag;
    logic signed [15:0] left_setpoint;
    logic signed [15:0] right_setpoint;
    logic        [31:0] stamp_ms;
    logic        [31:0] now_ms;

    modport source (
        output valid, action, req_source, seq_flag, left_setpoint, right_setpoint,
               stamp_ms, now_ms,
        input  ready
    );
    modport sink (
        input  valid, action, req_source, seq_flag, left_setpoint, right_setpoint,
               stamp_ms, now_ms,
        output ready
    );
endinterface : mcoa_cmd_if

// Result channel: status, owner, timeout verdict and the stored command.
interface mcoa_rsp_if import mcoa_pkg::*; ();
    logic               valid;
    logic               ready;
    t_status            status;
    logic        [2:0]  owner;
    logic               command_present;
    logic               timed_out;
    logic        [2:0]  cmd_source;
    logic               cmd_seq_flag;
    logic signed [15:0] cmd_left;
    logic signed [15:0] cmd_right;
    logic        [31:0] cmd_rcv_ms;

    modport source (
        output valid, status, owner, command_present, timed_out, cmd_source,
               cmd_seq_flag, cmd_left, cmd_right, cmd_rcv_ms,
        input  ready
    );
    modport sink (
        input  valid, status, owner, command_present, timed_out, cmd_source,
               cmd_seq_flag, cmd_left, cmd_right, cmd_rcv_ms,
        output ready
    );
endinterface : mcoa_rsp_if
`default_nettype wire

[hdl/motion_command_owner_arbiter.sv]
`default_nettype none
// A command transaction passes the input register and then the result register, which holds its result.
// Throughput: one transaction per cycle; the input register and the result
// register form a two-stage pipeline that stalls only on result backpressure.
// Reset (synchronous, active low) clears the owner and the stored command and
// restores target_limit to 10000 and timeout_ms to 100.
// ----------------------------------------------------------------------------
// motion_command_owner_arbiter
// Keeps the control owner and one active motion command. Each transaction
// acquires, releases, submits, refreshes, clears or queries, and returns a
// status, the owner, the stored command and its timeout verdict.
// ----------------------------------------------------------------------------
module motion_command_owner_arbiter
    import mcoa_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    mcoa_cmd_if.sink    i_cmd,
    mcoa_rsp_if.source  o_rsp,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers.
    logic [14:0] r_target_limit;
    logic [15:0] r_timeout_ms;

    // Input stage.
    logic               r_s1_valid;
    t_action            r_s1_action;
    logic        [2:0]  r_s1_source;
    logic               r_s1_seq;
    logic signed [15:0] r_s1_left;
    logic signed [15:0] r_s1_right;
    logic        [31:0] r_s1_stamp;
    logic        [31:0] r_s1_now;

    // Arbiter state, which also serves as the command part of the result.
    logic [2:0]  r_owner, n_owner;
    logic        r_cmd_valid, n_cmd_valid;
    logic [2:0]  r_cmd_source, n_cmd_source;
    logic        r_cmd_seq, n_cmd_seq;
    logic [15:0] r_cmd_left, n_cmd_left;
    logic [15:0] r_cmd_right, n_cmd_right;
    logic [31:0] r_cmd_rcv, n_cmd_rcv;

    // Result stage.
    logic        r_out_valid;
    t_status     r_out_status, n_status;
    logic        r_out_timed, n_timed;

    logic        s2_load;
    logic        may_take;
    logic        submit_ok;
    logic signed [16:0] lim_pos;
    logic signed [16:0] lim_neg;
    logic signed [16:0] left_x;
    logic signed [16:0] right_x;
    logic [31:0] age;

    // Pipeline handshake.
    assign s2_load     = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_cmd.ready = !r_s1_valid || s2_load;

    // APB register access.
    assign pready = 1'b1;
    always_comb begin
        if (paddr[2] == REG_TARGET_LIMIT) begin
            prdata = {17'd0, r_target_limit};
        end else begin
            prdata = {16'd0, r_timeout_ms};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_limit <= TARGET_LIMIT_RESET;
            r_timeout_ms   <= TIMEOUT_MS_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_TARGET_LIMIT) begin
                r_target_limit <= pwdata[14:0];
            end else begin
                r_timeout_ms <= pwdata[15:0];
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_s1_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_s1_action <= t_action'(i_cmd.action);
            r_s1_source <= i_cmd.req_source;
            r_s1_seq    <= i_cmd.seq_flag;
            r_s1_left   <= i_cmd.left_setpoint;
            r_s1_right  <= i_cmd.right_setpoint;
            r_s1_stamp  <= i_cmd.stamp_ms;
            r_s1_now    <= i_cmd.now_ms;
        end
    end

    // Argument checks for a submit: source, sequence flag and target range.
    assign lim_pos  = $signed({2'b00, r_target_limit});
    assign lim_neg  = -lim_pos;
    assign left_x   = 17'(r_s1_left);
    assign right_x  = 17'(r_s1_right);
    assign may_take = (r_owner == SRC_NONE) || (r_owner == r_s1_source);
    assign submit_ok = (r_s1_source >= SRC_REMOTE) && (r_s1_source <= SRC_SELFTEST)
                    && ((r_s1_source == SRC_REMOTE) == r_s1_seq)
                    && (left_x >= lim_neg) && (left_x <= lim_pos)
                    && (right_x >= lim_neg) && (right_x <= lim_pos);

    // Action decode and next state.
    always_comb begin
        n_owner      = r_owner;
        n_cmd_valid  = r_cmd_valid;
        n_cmd_source = r_cmd_source;
        n_cmd_seq    = r_cmd_seq;
        n_cmd_left   = r_cmd_left;
        n_cmd_right  = r_cmd_right;
        n_cmd_rcv    = r_cmd_rcv;
        n_status     = ST_OK;
        unique case (r_s1_action)
            ACT_ACQUIRE: begin
                if (r_s1_source >= SRC_REMOTE && r_s1_source <= SRC_UPDATE && may_take) begin
                    n_owner = r_s1_source;
                end else begin
                    n_status = ST_REFUSED;
                end
            end
            ACT_RELEASE: begin
                if (r_s1_source != SRC_NONE && r_owner == r_s1_source) begin
                    n_owner      = SRC_NONE;
                    n_cmd_valid  = 1'b0;
                    n_cmd_source = SRC_NONE;
                    n_cmd_seq    = 1'b0;
                    n_cmd_left   = '0;
                    n_cmd_right  = '0;
                    n_cmd_rcv    = '0;
                end
            end
            ACT_SUBMIT: begin
                if (!submit_ok) begin
                    n_status = ST_INVALID;
                end else if (!may_take) begin
                    n_status = ST_NOT_OWNER;
                end else begin
                    n_owner      = r_s1_source;
                    n_cmd_valid  = 1'b1;
                    n_cmd_source = r_s1_source;
                    n_cmd_seq    = r_s1_seq;
                    n_cmd_left   = r_s1_left;
                    n_cmd_right  = r_s1_right;
                    n_cmd_rcv    = r_s1_stamp;
                end
            end
            ACT_REFRESH: begin
                if (r_cmd_valid && r_s1_source != SRC_NONE && r_cmd_source == r_s1_source) begin
                    n_cmd_rcv = r_s1_now;
                end else begin
                    n_status = ST_REFUSED;
                end
            end
            ACT_CLEAR: begin
                n_cmd_valid  = 1'b0;
                n_cmd_source = SRC_NONE;
                n_cmd_seq    = 1'b0;
                n_cmd_left   = '0;
                n_cmd_right  = '0;
                n_cmd_rcv    = '0;
            end
            ACT_QUERY: begin
                n_status = ST_OK;
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
    end

    // Timeout verdict on the state after the action, with a wrapping age.
    assign age = r_s1_now - n_cmd_rcv;
    always_comb begin
        if (!n_cmd_valid) begin
            n_timed = 1'b1;
        end else if (n_cmd_source == SRC_REMOTE || n_cmd_source == SRC_SELFTEST) begin
            n_timed = (age >= {16'd0, r_timeout_ms});
        end else if (n_cmd_source == SRC_CONSOLE) begin
            n_timed = 1'b0;
        end else begin
            n_timed = 1'b1;
        end
    end

    // State and result register update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_owner      <= SRC_NONE;
            r_cmd_valid  <= 1'b0;
            r_cmd_source <= SRC_NONE;
            r_cmd_seq    <= 1'b0;
            r_cmd_left   <= '0;
            r_cmd_right  <= '0;
            r_cmd_rcv    <= '0;
        end else begin
            if (s2_load) begin
                r_out_valid  <= 1'b1;
                r_owner      <= n_owner;
                r_cmd_valid  <= n_cmd_valid;
                r_cmd_source <= n_cmd_source;
                r_cmd_seq    <= n_cmd_seq;
                r_cmd_left   <= n_cmd_left;
                r_cmd_right  <= n_cmd_right;
                r_cmd_rcv    <= n_cmd_rcv;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_out_status <= n_status;
            r_out_timed  <= n_timed;
        end
    end

    // Result channel; the stored command is zero whenever none is present.
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.owner           = r_owner;
    assign o_rsp.command_present = r_cmd_valid;
    assign o_rsp.timed_out       = r_out_timed;
    assign o_rsp.cmd_source      = r_cmd_source;
    assign o_rsp.cmd_seq_flag    = r_cmd_seq;
    assign o_rsp.cmd_left        = r_cmd_left;
    assign o_rsp.cmd_right       = r_cmd_right;
    assign o_rsp.cmd_rcv_ms      = r_cmd_rcv;

endmodule : motion_command_owner_arbiter
`default_nettype wire
